// ----- hdl/clebuf_pkg.sv -----
// Shared types and constants for the cursor line edit buffer.
// Holds command and status codes, field widths and the decode struct.
// No dependencies.
package clebuf_pkg;

	localparam int OPCODE_W = 3;
	localparam int CHAR_W   = 8;
	localparam int INDEX_W  = 10;
	localparam int COUNT_W  = 11;   // width of the reported cursor and length
	localparam int STATUS_W = 2;

	typedef enum logic [OPCODE_W-1:0] {
		OP_LEFT   = 3'd0,
		OP_RIGHT  = 3'd1,
		OP_BACK   = 3'd2,
		OP_INSERT = 3'd3,
		OP_READ   = 3'd4
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_DONE     = 2'd0,
		ST_BOUNDARY = 2'd1,
		ST_FULL     = 2'd2,
		ST_RANGE    = 2'd3
	} status_t;

	// Decision taken for one command in the first stage.
	typedef struct packed {
		logic    wr_en;       // command writes the text store in stage two
		logic    wr_from_rd;  // write data is the character read in stage one
		logic    is_read;     // result carries the character read
		status_t status;
	} dec_t;

endpackage

// ----- hdl/clebuf_ctrl.sv -----
// First stage of the line buffer: command register, cursor and length state.
// Decides each command and forms the gap-buffer read and write addresses.
// Depends on clebuf_pkg.
module clebuf_ctrl #(
	parameter int DEPTH = 1024
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               advance,
	input  logic                               cmd_valid,
	input  logic [clebuf_pkg::OPCODE_W-1:0]    opcode,
	input  logic [clebuf_pkg::CHAR_W-1:0]      char_value,
	input  logic [clebuf_pkg::INDEX_W-1:0]     read_index,
	output logic                               valid_s1,
	output clebuf_pkg::dec_t                   dec,
	output logic [$clog2(DEPTH)-1:0]           rd_addr,
	output logic [$clog2(DEPTH)-1:0]           wr_addr,
	output logic [clebuf_pkg::CHAR_W-1:0]      char_s1,
	output logic [$clog2(DEPTH+1)-1:0]         cursor_nxt,
	output logic [$clog2(DEPTH+1)-1:0]         len_nxt
);
	import clebuf_pkg::*;

	localparam int AW   = $clog2(DEPTH);
	localparam int CW   = $clog2(DEPTH + 1);
	localparam int CMPW = (CW > INDEX_W) ? CW : INDEX_W;
	localparam logic [CW-1:0] DepthC = CW'(DEPTH);

	logic [OPCODE_W-1:0] opcode_s1;
	logic [INDEX_W-1:0]  index_s1;
	logic [CW-1:0]       cursor_q;
	logic [CW-1:0]       len_q;
	logic [CW-1:0]       gap_len;
	logic [CW-1:0]       right_start;
	logic [CMPW-1:0]     index_w;
	logic [CMPW:0]       index_far;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= cmd_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && cmd_valid) begin
			opcode_s1 <= opcode;
			char_s1   <= char_value;
			index_s1  <= read_index;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_q <= '0;
			len_q    <= '0;
		end else if (advance && valid_s1) begin
			cursor_q <= cursor_nxt;
			len_q    <= len_nxt;
		end
	end

	// Text left of the cursor sits at [0, cursor), text right of it at
	// [right_start, DEPTH); the gap lies between.
	assign gap_len     = DepthC - len_q;
	assign right_start = gap_len + cursor_q;
	assign index_w     = CMPW'(index_s1);
	assign index_far   = {1'b0, index_w} + (CMPW + 1)'(gap_len);

	always_comb begin
		dec        = '{wr_en: 1'b0, wr_from_rd: 1'b0, is_read: 1'b0, status: ST_DONE};
		rd_addr    = '0;
		wr_addr    = '0;
		cursor_nxt = cursor_q;
		len_nxt    = len_q;
		unique case (op_t'(opcode_s1))
			OP_LEFT: begin
				if (cursor_q != '0) begin
					// last char of the left part moves to just below the right part
					rd_addr        = AW'(cursor_q - 1'b1);
					wr_addr        = AW'(right_start - 1'b1);
					dec.wr_en      = 1'b1;
					dec.wr_from_rd = 1'b1;
					cursor_nxt     = cursor_q - 1'b1;
				end else begin
					dec.status = ST_BOUNDARY;
				end
			end
			OP_RIGHT: begin
				if (cursor_q != len_q) begin
					rd_addr        = AW'(right_start);
					wr_addr        = AW'(cursor_q);
					dec.wr_en      = 1'b1;
					dec.wr_from_rd = 1'b1;
					cursor_nxt     = cursor_q + 1'b1;
				end else begin
					dec.status = ST_BOUNDARY;
				end
			end
			OP_BACK: begin
				if (cursor_q != '0) begin
					cursor_nxt = cursor_q - 1'b1;
					len_nxt    = len_q - 1'b1;
				end else begin
					dec.status = ST_BOUNDARY;
				end
			end
			OP_INSERT: begin
				if (len_q != DepthC) begin
					wr_addr    = AW'(cursor_q);
					dec.wr_en  = 1'b1;
					cursor_nxt = cursor_q + 1'b1;
					len_nxt    = len_q + 1'b1;
				end else begin
					dec.status = ST_FULL;
				end
			end
			OP_READ: begin
				if (index_w < CMPW'(len_q)) begin
					dec.is_read = 1'b1;
					if (index_w < CMPW'(cursor_q)) begin
						rd_addr = AW'(index_s1);
					end else begin
						rd_addr = AW'(index_far);
					end
				end else begin
					dec.status = ST_RANGE;
				end
			end
			default: begin
				dec.status = ST_BOUNDARY;
			end
		endcase
	end

endmodule

// ----- hdl/clebuf_store.sv -----
// Text store of the line buffer: one write port, one registered read port.
// Forwards a write that lands on the address read at the same edge.
// Depends on clebuf_pkg.
module clebuf_store #(
	parameter int DEPTH = 1024
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          advance,
	input  logic                          wr_en,
	input  logic [$clog2(DEPTH)-1:0]      wr_addr,
	input  logic [clebuf_pkg::CHAR_W-1:0] wr_data,
	input  logic [$clog2(DEPTH)-1:0]      rd_addr,
	output logic [clebuf_pkg::CHAR_W-1:0] rd_data
);
	import clebuf_pkg::*;

	logic [CHAR_W-1:0] mem [DEPTH];
	logic [CHAR_W-1:0] rd_q;
	logic [CHAR_W-1:0] fwd_data_q;
	logic              fwd_hit_q;

	always_ff @(posedge clk) begin
		if (advance) begin
			if (wr_en) begin
				mem[wr_addr] <= wr_data;
			end
			rd_q       <= mem[rd_addr];
			fwd_data_q <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_hit_q <= 1'b0;
		end else if (advance) begin
			fwd_hit_q <= wr_en && (wr_addr == rd_addr);
		end
	end

	assign rd_data = fwd_hit_q ? fwd_data_q : rd_q;

endmodule

// ----- hdl/cursor_line_edit_buffer.sv -----
// Top level of the cursor line edit buffer (gap buffer line editor).
// Instantiates clebuf_ctrl and clebuf_store; depends on clebuf_pkg.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+------------------------------------
//   cmd     | in        | cmd_valid / cmd_stall | opcode, char_value, read_index
//   rsp     | out       | rsp_valid / rsp_stall | cursor_pos, text_len, read_char, status
//
// One transaction per clock in each direction unless a held result is stalled;
// each command gives one result (command register, store read, result register).
// Rate is set by the text store: one read and one write port, and a cursor move
// reads one entry in stage one and writes it back in stage two.
// Reset clears cursor, length and all valid flags; the store content is not cleared.
// rsp_stall with a result held freezes the whole pipe and raises cmd_stall.
module cursor_line_edit_buffer #(
	parameter int DEPTH = 1024
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cmd_valid,
	output logic                               cmd_stall,
	input  logic [clebuf_pkg::OPCODE_W-1:0]    opcode,
	input  logic [clebuf_pkg::CHAR_W-1:0]      char_value,
	input  logic [clebuf_pkg::INDEX_W-1:0]     read_index,
	output logic                               rsp_valid,
	input  logic                               rsp_stall,
	output logic [clebuf_pkg::COUNT_W-1:0]     cursor_pos,
	output logic [clebuf_pkg::COUNT_W-1:0]     text_len,
	output logic [clebuf_pkg::CHAR_W-1:0]      read_char,
	output logic [clebuf_pkg::STATUS_W-1:0]    status
);
	import clebuf_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	// pipe moves as a whole unless a held result is stalled
	logic advance;

	// stage one outputs
	logic              valid_s1;
	dec_t              dec;
	logic [AW-1:0]     rd_addr;
	logic [AW-1:0]     wr_addr;
	logic [CHAR_W-1:0] char_s1;
	logic [CW-1:0]     cursor_nxt;
	logic [CW-1:0]     len_nxt;

	// stage two registers
	logic              valid_s2;
	dec_t              dec_s2;
	logic [AW-1:0]     wr_addr_s2;
	logic [CHAR_W-1:0] char_s2;
	logic [CW-1:0]     cursor_s2;
	logic [CW-1:0]     len_s2;

	logic              wr_en;
	logic [CHAR_W-1:0] wr_data;
	logic [CHAR_W-1:0] rd_data;

	assign advance   = !(rsp_valid && rsp_stall);
	assign cmd_stall = !advance;

	clebuf_ctrl #(
		.DEPTH(DEPTH)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.advance    (advance),
		.cmd_valid  (cmd_valid),
		.opcode     (opcode),
		.char_value (char_value),
		.read_index (read_index),
		.valid_s1   (valid_s1),
		.dec        (dec),
		.rd_addr    (rd_addr),
		.wr_addr    (wr_addr),
		.char_s1    (char_s1),
		.cursor_nxt (cursor_nxt),
		.len_nxt    (len_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			dec_s2     <= dec;
			wr_addr_s2 <= wr_addr;
			char_s2    <= char_s1;
			cursor_s2  <= cursor_nxt;
			len_s2     <= len_nxt;
		end
	end

	// cursor moves carry the character across the gap; insert writes the new one
	assign wr_en   = advance && valid_s2 && dec_s2.wr_en;
	assign wr_data = dec_s2.wr_from_rd ? rd_data : char_s2;

	clebuf_store #(
		.DEPTH(DEPTH)
	) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.wr_en   (wr_en),
		.wr_addr (wr_addr_s2),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid <= 1'b0;
		end else if (advance) begin
			rsp_valid <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s2) begin
			cursor_pos <= COUNT_W'(cursor_s2);
			text_len   <= COUNT_W'(len_s2);
			read_char  <= dec_s2.is_read ? rd_data : '0;
			status     <= dec_s2.status;
		end
	end

endmodule

// ----- verif/testbench.sv -----
// Self-checking testbench for cursor_line_edit_buffer, the gap buffer line editor.
// Holds a line predictor, a result checker and the drive tasks in one top module.
// Depends on clebuf_pkg and the RTL under hdl/.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import clebuf_pkg::*;

	localparam int LINE_DEPTH  = 1024;
	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_CYCLES = 300;
	localparam int GROW_LEN    = 96;   // line length reached by the long-line excursion
	localparam int TRIM_LEN    = 8;    // line length the excursion cuts back to

	// opcodes with no command behind them
	localparam logic [OPCODE_W-1:0] OP_SPARE_LO  = 3'd5;
	localparam logic [OPCODE_W-1:0] OP_SPARE_MID = 3'd6;
	localparam logic [OPCODE_W-1:0] OP_SPARE_HI  = 3'd7;

	typedef struct {
		logic [COUNT_W-1:0] caret;
		logic [COUNT_W-1:0] length;
		logic [CHAR_W-1:0]  char_out;
		status_t            code;
	} edit_result_t;

	// Line predictor plus in-order result checker. apply_command runs one accepted
	// command against the predicted line; check_result pops the oldest expectation.
	class line_checker;
		byte unsigned   line_q[$];
		int unsigned    caret;
		edit_result_t   pending_results[$];
		int unsigned    mismatches;

		function new();
			caret = 0;
			mismatches = 0;
		endfunction

		function int unsigned length();
			return line_q.size();
		endfunction

		function int unsigned caret_pos();
			return caret;
		endfunction

		function int unsigned outstanding();
			return pending_results.size();
		endfunction

		function void apply_command(logic [OPCODE_W-1:0] op, logic [CHAR_W-1:0] ch,
				logic [INDEX_W-1:0] idx);
			edit_result_t r;
			r.char_out = '0;
			r.code     = ST_DONE;
			case (op)
				OP_LEFT: begin
					if (caret > 0) caret--;
					else r.code = ST_BOUNDARY;
				end
				OP_RIGHT: begin
					if (caret < line_q.size()) caret++;
					else r.code = ST_BOUNDARY;
				end
				OP_BACK: begin
					if (caret > 0) begin
						line_q.delete(caret - 1);
						caret--;
					end else begin
						r.code = ST_BOUNDARY;
					end
				end
				OP_INSERT: begin
					if (line_q.size() >= LINE_DEPTH) begin
						r.code = ST_FULL;
					end else begin
						line_q.insert(caret, ch);
						caret++;
					end
				end
				OP_READ: begin
					if (idx < line_q.size()) r.char_out = line_q[idx];
					else r.code = ST_RANGE;
				end
				default: r.code = ST_BOUNDARY;
			endcase
			r.caret  = COUNT_W'(caret);
			r.length = COUNT_W'(line_q.size());
			pending_results.push_back(r);
		endfunction

		task report(string what);
			mismatches++;
			if (mismatches <= 40) $display("mismatch: %s", what);
		endtask

		task check_result(logic [COUNT_W-1:0] cur, logic [COUNT_W-1:0] len,
				logic [CHAR_W-1:0] rd, logic [STATUS_W-1:0] st);
			edit_result_t e;
			if (pending_results.size() == 0) begin
				report("result transaction with no command outstanding");
			end else begin
				e = pending_results.pop_front();
				if (cur !== e.caret)
					report($sformatf("cursor_pos %0d, expected %0d", cur, e.caret));
				if (len !== e.length)
					report($sformatf("text_len %0d, expected %0d", len, e.length));
				if (rd !== e.char_out)
					report($sformatf("read_char %0h, expected %0h", rd, e.char_out));
				if (st !== e.code)
					report($sformatf("status %0d, expected %0d", st, e.code));
			end
		endtask
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 cmd_valid;
	logic                 cmd_stall;
	logic [OPCODE_W-1:0]  opcode;
	logic [CHAR_W-1:0]    char_value;
	logic [INDEX_W-1:0]   read_index;
	logic                 rsp_valid;
	logic                 rsp_stall;
	logic [COUNT_W-1:0]   cursor_pos;
	logic [COUNT_W-1:0]   text_len;
	logic [CHAR_W-1:0]    read_char;
	logic [STATUS_W-1:0]  status;

	line_checker sb = new();

	int unsigned tx_idle_pct;  // chance of an idle command cycle before each offer
	int unsigned rx_idle_pct;  // chance of stalling the result channel each cycle
	int unsigned hold_left;    // cycles of forced result stall still to run
	int unsigned cycle_count;

	cursor_line_edit_buffer #(
		.DEPTH(LINE_DEPTH)
	) u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (cmd_valid),
		.cmd_stall  (cmd_stall),
		.opcode     (opcode),
		.char_value (char_value),
		.read_index (read_index),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.cursor_pos (cursor_pos),
		.text_len   (text_len),
		.read_char  (read_char),
		.status     (status)
	);

	// 8 ns clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Watchdog: a hung handshake or a lost result ends here.
	initial begin
		cycle_count = 0;
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count >= CYCLE_LIMIT) begin
				$display("FAILURE");
				$finish;
			end
		end
	end

	// Result-side stall. A requested hold-off is counted down here, in its own
	// process, so the sender keeps offering commands while the pipe backs up.
	initial begin
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				rsp_stall <= 1'b1;
				hold_left--;
			end else begin
				rsp_stall <= ($urandom_range(99) < rx_idle_pct);
			end
		end
	end

	// Result monitor: samples pre-edge values, so DUT updates at this edge don't race.
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall)
			sb.check_result(cursor_pos, text_len, read_char, status);
	end

	// Offer one command and block until it is taken. valid stays high across
	// back-to-back transactions; each idle cycle holds it low.
	task automatic send_command(input logic [OPCODE_W-1:0] op, input logic [CHAR_W-1:0] ch,
			input logic [INDEX_W-1:0] idx);
		while ($urandom_range(99) < tx_idle_pct) begin
			cmd_valid <= 1'b0;
			@(posedge clk);
		end
		cmd_valid  <= 1'b1;
		opcode     <= op;
		char_value <= ch;
		read_index <= idx;
		@(posedge clk);
		while (cmd_stall) @(posedge clk);
		sb.apply_command(op, ch, idx);
	endtask

	// Sender pause: no command offered until every result is back.
	task automatic wait_drained();
		cmd_valid <= 1'b0;
		while (sb.outstanding() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// One random command, weighted toward edits and valid reads; junk payload
	// on fields the opcode ignores. Spare opcodes show up now and then.
	task automatic random_command();
		int unsigned pick;
		int unsigned len;
		logic [OPCODE_W-1:0] op;
		logic [CHAR_W-1:0]   ch;
		logic [INDEX_W-1:0]  idx;
		len  = sb.length();
		pick = $urandom_range(99);
		ch   = CHAR_W'($urandom_range(255));
		idx  = INDEX_W'($urandom_range(1023));
		if (pick < 32) op = OP_INSERT;
		else if (pick < 44) op = OP_LEFT;
		else if (pick < 56) op = OP_RIGHT;
		else if (pick < 70) op = OP_BACK;
		else if (pick < 95) begin
			op = OP_READ;
			if (len > 0 && $urandom_range(3) != 0) idx = INDEX_W'($urandom_range(len - 1));
		end else begin
			op = OP_SPARE_LO + OPCODE_W'($urandom_range(2));
		end
		send_command(op, ch, idx);
	endtask

	// Grow the line to a long one, poke the far end, then cut it back down
	// with backspaces from near the end.
	task automatic grow_and_trim();
		int unsigned pick;
		int unsigned len;
		while (sb.length() < GROW_LEN) begin
			pick = $urandom_range(99);
			len  = sb.length();
			if (pick < 76)
				send_command(OP_INSERT, CHAR_W'($urandom_range(255)),
					INDEX_W'($urandom_range(1023)));
			else if (pick < 84)
				send_command(OP_LEFT, CHAR_W'($urandom_range(255)),
					INDEX_W'($urandom_range(1023)));
			else if (pick < 90)
				send_command(OP_RIGHT, CHAR_W'($urandom_range(255)),
					INDEX_W'($urandom_range(1023)));
			else
				send_command(OP_READ, CHAR_W'($urandom_range(255)),
					(len > 0) ? INDEX_W'($urandom_range(len - 1)) : '0);
		end
		while (sb.caret_pos() < sb.length())
			send_command(OP_RIGHT, 8'h00, 10'h000);
		send_command(OP_RIGHT, 8'h00, 10'h000);     // right at end
		send_command(OP_READ, 8'h00, INDEX_W'(sb.length() - 1));  // last char
		send_command(OP_READ, 8'hFF, INDEX_W'(sb.length()));      // just past end
		send_command(OP_LEFT, 8'h00, 10'h000);
		send_command(OP_INSERT, 8'h50, 10'h000);    // insert next to the end
		send_command(OP_RIGHT, 8'h00, 10'h000);
		while (sb.length() > TRIM_LEN) begin
			pick = $urandom_range(99);
			len  = sb.length();
			if (sb.caret_pos() == 0)
				send_command(OP_RIGHT, CHAR_W'($urandom_range(255)),
					INDEX_W'($urandom_range(1023)));
			else if (pick < 72)
				send_command(OP_BACK, CHAR_W'($urandom_range(255)),
					INDEX_W'($urandom_range(1023)));
			else if (pick < 80)
				send_command(OP_LEFT, CHAR_W'($urandom_range(255)),
					INDEX_W'($urandom_range(1023)));
			else if (pick < 88)
				send_command(OP_RIGHT, CHAR_W'($urandom_range(255)),
					INDEX_W'($urandom_range(1023)));
			else
				send_command(OP_READ, CHAR_W'($urandom_range(255)),
					INDEX_W'($urandom_range(len - 1)));
		end
	endtask

	// Boundary cases on an empty line, extreme payload values, spare opcodes and
	// edits in the middle of a short line.
	task automatic directed_commands();
		send_command(OP_LEFT, 8'h00, 10'h000);      // left at start
		send_command(OP_RIGHT, 8'hFF, 10'h3FF);     // right at end of empty line
		send_command(OP_BACK, 8'h00, 10'h000);      // backspace at start
		send_command(OP_READ, 8'h00, 10'h000);      // read past length
		send_command(OP_READ, 8'hFF, 10'h3FF);
		send_command(OP_SPARE_LO, 8'hFF, 10'h3FF);
		send_command(OP_SPARE_MID, 8'h00, 10'h000);
		send_command(OP_SPARE_HI, 8'hA5, 10'h155);
		send_command(OP_INSERT, 8'h00, 10'h3FF);
		send_command(OP_INSERT, 8'hFF, 10'h000);
		send_command(OP_INSERT, 8'hA5, 10'h2AA);
		send_command(OP_INSERT, 8'h5A, 10'h155);
		send_command(OP_LEFT, 8'h00, 10'h000);
		send_command(OP_LEFT, 8'h00, 10'h000);
		send_command(OP_INSERT, 8'h4C, 10'h000);    // insert mid-line
		send_command(OP_RIGHT, 8'h00, 10'h000);
		send_command(OP_BACK, 8'h00, 10'h000);      // delete mid-line
		send_command(OP_READ, 8'h00, 10'h000);
		send_command(OP_READ, 8'h00, 10'h002);
		send_command(OP_READ, 8'hFF, 10'h003);
		send_command(OP_READ, 8'h00, 10'h004);      // exactly at length
		send_command(OP_RIGHT, 8'h00, 10'h000);
		send_command(OP_RIGHT, 8'h00, 10'h000);     // right at end
		send_command(OP_SPARE_HI, 8'h00, 10'h000);
	endtask

	initial begin
		arst_n      <= 1'b0;
		cmd_valid   <= 1'b0;
		opcode      <= OP_LEFT;
		char_value  <= '0;
		read_index  <= '0;
		rsp_stall   <= 1'b0;
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		hold_left   = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		directed_commands();

		// sender idles often, receiver more often
		tx_idle_pct = 30;
		rx_idle_pct = 61;
		repeat (140) random_command();
		wait_drained();

		// roles swapped; a long result hold-off backs the pipe up into cmd_stall
		tx_idle_pct = 61;
		rx_idle_pct = 30;
		hold_left = HOLD_CYCLES;
		repeat (30) random_command();
		repeat (110) random_command();
		wait_drained();

		// full rate both ways, then the long-line excursion
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		repeat (80) random_command();
		grow_and_trim();

		cmd_valid <= 1'b0;
		while (sb.outstanding() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (sb.mismatches == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

// ----- files.f -----
hdl/clebuf_pkg.sv
hdl/clebuf_ctrl.sv
hdl/clebuf_store.sv
hdl/cursor_line_edit_buffer.sv
verif/testbench.sv
